### design/smsc_pkg.sv
// Shared types and constants for the stream marker spacing checker.
// Holds the result record, register indexes and marker byte selection.
// No dependencies.
package smsc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int EXT_WIDTH   = COUNT_WIDTH + 32;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPECTED_SPACING = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MARKER_PATTERN   = 8'd1;

  localparam logic [15:0] EXPECTED_SPACING_RESET = 16'd10000;
  localparam logic [31:0] MARKER_PATTERN_RESET   = 32'hAABB_CCDD;

  localparam logic [15:0] ERROR_MAX   = 16'hFFFF;
  localparam logic [31:0] DEFICIT_MAX = 32'hFFFF_FFFF;

  localparam int RESULT_DATA_WIDTH = 96;

  typedef struct packed {
    logic        buffer_end;
    logic [31:0] buffer_deficit;
    logic [15:0] error_total;
    logic        packet_step_ok;
    logic [7:0]  seq_id;
    logic [31:0] spacing;
    logic        spacing_error;
    logic        marker_report;
  } smsc_result_t;

  // Marker byte k of the pattern, first byte in the top bits.
  function automatic logic [7:0] pattern_byte(input logic [31:0] pattern,
                                              input logic [1:0]  k);
    logic [7:0] b;
    unique case (k)
      2'd0:    b = pattern[31:24];
      2'd1:    b = pattern[23:16];
      2'd2:    b = pattern[15:8];
      default: b = pattern[7:0];
    endcase
    return b;
  endfunction

endpackage

### design/smsc_out_skid.sv
// Output register with one skid entry for the checker's result stream.
// Depends on smsc_pkg for the result record.
module smsc_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  smsc_pkg::smsc_result_t in_data,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output smsc_pkg::smsc_result_t out_data
);
  import smsc_pkg::*;

  smsc_result_t skid_data;
  logic         skid_valid;
  logic         pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_stall_holds_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_data))
    else $error("skid entry changed while stalled");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && in_ready && !out_valid |=> out_valid && out_data == $past(in_data))
    else $error("pushed result not loaded into output register");
`endif

endmodule

### design/stream_marker_spacing_checker.sv
// Top level of the stream marker spacing checker.
// Depends on smsc_pkg and smsc_out_skid.
//
// Takes one stream byte per cycle on s_* and searches for a four-byte marker
// (marker_pattern, first byte in the top bits, AA BB CC DD after reset). When
// a marker completes, the byte count since the previous completion is held
// and the next byte is taken as the packet id; that byte yields a result on
// m_* with the spacing, the id, whether the id rose by exactly one, and the
// saturating spacing error total. Short spacings with a good id step add
// their shortfall to a saturating per-buffer deficit, reported and cleared on
// the byte that carries s_tlast. A byte gives a result when it reports a
// marker, closes a buffer, or both; other bytes give none. One byte is taken
// every cycle while s_tready is high: the state update is a single pass of
// logic per byte, and the result appears on m_* the cycle after its byte is
// taken when the output register is free. The output register plus one skid
// entry lets input continue while a result waits; s_tready drops only when
// both hold results. Configuration writes on cfg_* are always taken and must
// be made while the stream is idle. No clearing pass is needed after reset.
module stream_marker_spacing_checker (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: data_byte [7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // m_tdata: spacing_error [0], spacing [32:1], seq_id [40:33],
  //          packet_step_ok [41], error_total [57:42], buffer_deficit [89:58],
  //          zero fill [95:90]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,
  // m_tuser: marker_report [0]
  output logic        m_tuser,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import smsc_pkg::*;

  // Configuration registers
  logic [15:0] expected_spacing;
  logic [31:0] marker_pattern;

  // Checker state
  logic [1:0]             match_count;
  logic [COUNT_WIDTH-1:0] byte_count;
  logic [COUNT_WIDTH-1:0] last_marker_position;
  logic                   pending_marker;
  logic [COUNT_WIDTH-1:0] pending_spacing;
  logic [7:0]             previous_seq_id;
  logic [15:0]            error_counter;
  logic [31:0]            deficit_sum;

  logic [1:0]             match_count_next;
  logic [COUNT_WIDTH-1:0] byte_count_next;
  logic                   completed;
  logic [15:0]            error_counter_next;
  logic [31:0]            deficit_sum_next;

  logic                   in_acc;
  logic                   push;
  logic                   skid_ready;
  smsc_result_t           result;
  smsc_result_t           out_result;

  logic [EXT_WIDTH-1:0]   sp_ext;
  logic [EXT_WIDTH-1:0]   exp_ext;
  logic [EXT_WIDTH-1:0]   shortfall_ext;
  logic [7:0]             pid_step;
  logic                   step_ok;
  logic                   sp_mismatch;
  logic                   sp_short;
  logic [32:0]            deficit_add;
  logic [31:0]            deficit_acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = skid_ready;
  assign in_acc    = s_tvalid && s_tready;

  // Spacing compare at full counter width; the shortfall fits in 16 bits.
  assign sp_ext        = {32'd0, pending_spacing};
  assign exp_ext       = {{(EXT_WIDTH-16){1'b0}}, expected_spacing};
  assign shortfall_ext = exp_ext - sp_ext;
  assign pid_step      = s_tdata - previous_seq_id;
  assign step_ok       = (pid_step == 8'd1);
  assign sp_mismatch   = (sp_ext != exp_ext);
  assign sp_short      = (sp_ext < exp_ext) && step_ok;
  assign deficit_add   = {1'b0, deficit_sum} + {17'd0, shortfall_ext[15:0]};

  always_comb begin
    byte_count_next    = byte_count + COUNT_WIDTH'(1);
    error_counter_next = error_counter;
    deficit_acc        = deficit_sum;

    // Packet id byte: report the held marker
    if (pending_marker && sp_mismatch) begin
      if (error_counter != ERROR_MAX) begin
        error_counter_next = error_counter + 16'd1;
      end
      if (sp_short) begin
        deficit_acc = deficit_add[32] ? DEFICIT_MAX : deficit_add[31:0];
      end
    end

    // Marker search; a broken match restarts on the first marker byte
    completed = 1'b0;
    if (s_tdata == pattern_byte(marker_pattern, match_count)) begin
      match_count_next = match_count + 2'd1;
      completed        = (match_count == 2'd3);
    end else if (s_tdata == pattern_byte(marker_pattern, 2'd0)) begin
      match_count_next = 2'd1;
    end else begin
      match_count_next = 2'd0;
    end

    deficit_sum_next = s_tlast ? 32'd0 : deficit_acc;

    result.marker_report  = pending_marker;
    result.spacing_error  = pending_marker && sp_mismatch;
    result.spacing        = pending_marker ? sp_ext[31:0] : 32'd0;
    result.seq_id         = pending_marker ? s_tdata : 8'd0;
    result.packet_step_ok = pending_marker && step_ok;
    result.error_total    = error_counter_next;
    result.buffer_deficit = s_tlast ? deficit_acc : 32'd0;
    result.buffer_end     = s_tlast;
  end

  assign push = in_acc && (pending_marker || s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_spacing     <= EXPECTED_SPACING_RESET;
      marker_pattern       <= MARKER_PATTERN_RESET;
      match_count          <= 2'd0;
      byte_count           <= '0;
      last_marker_position <= '0;
      pending_marker       <= 1'b0;
      pending_spacing      <= '0;
      previous_seq_id      <= 8'd0;
      error_counter        <= 16'd0;
      deficit_sum          <= 32'd0;
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_EXPECTED_SPACING: expected_spacing <= cfg_data[15:0];
          REG_MARKER_PATTERN:   marker_pattern   <= cfg_data;
          default: ;
        endcase
      end
      // Advance on every byte transaction
      if (in_acc) begin
        byte_count    <= byte_count_next;
        match_count   <= match_count_next;
        error_counter <= error_counter_next;
        deficit_sum   <= deficit_sum_next;
        if (pending_marker) begin
          previous_seq_id <= s_tdata;
        end
        // Hold a completed marker until its packet id byte arrives
        pending_marker <= completed;
        if (completed) begin
          pending_spacing      <= byte_count_next - last_marker_position;
          last_marker_position <= byte_count_next;
        end
      end
    end
  end

  smsc_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_data   (result),
    .in_ready  (skid_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tuser = out_result.marker_report;
  assign m_tlast = out_result.buffer_end;
  assign m_tdata = {6'd0,
                    out_result.buffer_deficit,
                    out_result.error_total,
                    out_result.packet_step_ok,
                    out_result.seq_id,
                    out_result.spacing,
                    out_result.spacing_error};

`ifndef SYNTHESIS
  a_errors_never_drop: assert property (@(posedge clk) disable iff (rst)
    error_counter >= $past(error_counter))
    else $error("spacing error counter decreased");

  a_pending_reported: assert property (@(posedge clk) disable iff (rst)
    in_acc && pending_marker |-> push && result.marker_report)
    else $error("held marker not reported on its packet id byte");

  a_no_marker_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[41:0] == 42'd0)
    else $error("marker fields set in a result without a marker");

  a_deficit_cleared: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |=> deficit_sum == 32'd0)
    else $error("deficit not cleared at buffer end");
`endif

endmodule
